@@ sv/rrmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmq_pkg
// shared constants, types and helpers of the round-robin multi-queue scheduler
// ----------------------------------------------------------------------------
package rrmq_pkg;

	// queue count must be a power of two: the queue is the id's low bits
	localparam int NUM_QUEUES  = 4;
	localparam int QUEUE_DEPTH = 64;
	localparam int CMDQ_DEPTH  = 2;

	localparam int ID_W      = 16;
	localparam int OUT_Q_W   = 2;
	localparam int QIDX_W    = $clog2(NUM_QUEUES);
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_N   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(STORE_N);
	localparam int CMDQ_PW   = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW   = $clog2(CMDQ_DEPTH + 1);

	localparam logic OP_ENQ  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic {
		KIND_SERVED = 1'b0,
		KIND_DROP   = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_DROP  = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic [QIDX_W-1:0]  q;
		logic [ADDR_W-1:0]  addr;
		logic [ID_W-1:0]    id;
	} cmd_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [QIDX_W-1:0] q,
			input logic [PTR_W-1:0] p);
		return ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p));
	endfunction

endpackage

@@ sv/rrmq_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmq_req_if
// request channel: enqueue or service tick words
// ----------------------------------------------------------------------------
interface rrmq_req_if
	import rrmq_pkg::*;
();
	logic            valid;
	logic            ready;
	logic            op;
	logic [ID_W-1:0] session_id;

	modport source(output valid, output op, output session_id, input ready);
	modport sink(input valid, input op, input session_id, output ready);
endinterface

@@ sv/rrmq_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmq_rsp_if
// response channel: served or dropped session ids
// ----------------------------------------------------------------------------
interface rrmq_rsp_if
	import rrmq_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [ID_W-1:0]    served_id;
	logic [OUT_Q_W-1:0] queue_index;

	modport source(output valid, output kind, output served_id, output queue_index,
		input ready);
	modport sink(input valid, input kind, input served_id, input queue_index,
		output ready);
endinterface

@@ sv/rrmq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rrmq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

@@ sv/rrmq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmq_front
// accepts words, keeps queue pointers and counts, picks the queue to serve
// ----------------------------------------------------------------------------
module rrmq_front
	import rrmq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	rrmq_req_if.sink     req,
	output cmd_t         cmd,
	output logic         cmd_valid,
	input  logic         cmd_ready
);
	logic [PTR_W-1:0]  head_q [NUM_QUEUES];
	logic [PTR_W-1:0]  tail_q [NUM_QUEUES];
	logic [CNT_W-1:0]  cnt_q  [NUM_QUEUES];
	logic [QIDX_W-1:0] start_q;

	logic              accept;
	logic [QIDX_W-1:0] q_enq;
	logic              enq_full;
	logic              found;
	logic [QIDX_W-1:0] q_srv;

	assign req.ready = cmd_ready;
	assign accept    = req.valid && cmd_ready;
	assign q_enq     = req.session_id[QIDX_W-1:0];
	assign enq_full  = (cnt_q[q_enq] == CNT_W'(QUEUE_DEPTH));

	// round-robin scan from the start pointer
	always_comb begin
		logic [QIDX_W-1:0] cand;
		found = 1'b0;
		q_srv = '0;
		for (int k = 0; k < NUM_QUEUES; k++) begin
			cand = QIDX_W'(start_q + QIDX_W'(k));
			if (!found && cnt_q[cand] != '0) begin
				found = 1'b1;
				q_srv = cand;
			end
		end
	end

	always_comb begin
		cmd_valid = accept && (req.op == OP_ENQ || found);
		cmd.id    = req.session_id;
		if (req.op == OP_ENQ) begin
			cmd.op   = enq_full ? CMD_DROP : CMD_WRITE;
			cmd.q    = q_enq;
			cmd.addr = store_addr(q_enq, tail_q[q_enq]);
		end else begin
			cmd.op   = CMD_READ;
			cmd.q    = q_srv;
			cmd.addr = store_addr(q_srv, head_q[q_srv]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (accept) begin
			if (req.op == OP_ENQ) begin
				if (!enq_full) begin
					tail_q[q_enq] <= ptr_next(tail_q[q_enq]);
					cnt_q[q_enq]  <= CNT_W'(cnt_q[q_enq] + 1'b1);
				end
			end else begin
				start_q <= QIDX_W'(start_q + 1'b1);
				if (found) begin
					head_q[q_srv] <= ptr_next(head_q[q_srv]);
					cnt_q[q_srv]  <= CNT_W'(cnt_q[q_srv] - 1'b1);
				end
			end
		end
	end
endmodule

@@ sv/rrmq_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmq_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module rrmq_cmd_fifo
	import rrmq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t push_data,
	input  logic push_valid,
	output logic push_ready,
	output cmd_t pop_data,
	output logic pop_valid,
	input  logic pop_ready
);
	cmd_t               slot_q [CMDQ_DEPTH];
	logic [CMDQ_PW-1:0] wr_ptr_q;
	logic [CMDQ_PW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != CMDQ_CW'(CMDQ_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 :
					CMDQ_PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 :
					CMDQ_PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CMDQ_CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CMDQ_CW'(count_q - 1'b1);
			end
		end
	end
endmodule

@@ sv/rrmq_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrmq_back
// carries out store writes, pops and drops, and registers the response word
// ----------------------------------------------------------------------------
module rrmq_back
	import rrmq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_t     cmd,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	rrmq_rsp_if.source rsp
);
	logic              s1_valid_s1;
	kind_t             kind_s1;
	logic [QIDX_W-1:0] q_s1;
	logic [ID_W-1:0]   id_s1;

	logic              rsp_valid_q;
	kind_t             rsp_kind_q;
	logic [ID_W-1:0]   rsp_id_q;
	logic [OUT_Q_W-1:0] rsp_q_q;

	logic              out_free;
	logic              s1_free;
	logic              pop;
	logic [ID_W-1:0]   rd_data;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign s1_free  = !s1_valid_s1 || out_free;
	assign pop      = cmd_valid && cmd_ready;

	always_comb begin
		unique case (cmd.op)
			CMD_WRITE:          cmd_ready = 1'b1;
			CMD_READ, CMD_DROP: cmd_ready = s1_free;
			default:            cmd_ready = 1'b0;
		endcase
	end

	rrmq_ram #(
		.WIDTH(ID_W),
		.DEPTH(STORE_N)
	) u_store (
		.clk    (clk),
		.wr_en  (pop && cmd.op == CMD_WRITE),
		.wr_addr(cmd.addr),
		.wr_data(cmd.id),
		.rd_en  (pop && cmd.op == CMD_READ),
		.rd_addr(cmd.addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (pop && cmd.op != CMD_WRITE) begin
			kind_s1 <= (cmd.op == CMD_DROP) ? KIND_DROP : KIND_SERVED;
			q_s1    <= cmd.q;
			id_s1   <= cmd.id;
		end
		if (out_free && s1_valid_s1) begin
			rsp_kind_q <= kind_s1;
			rsp_id_q   <= (kind_s1 == KIND_DROP) ? id_s1 : rd_data;
			rsp_q_q    <= OUT_Q_W'(q_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_s1 <= pop && cmd.op != CMD_WRITE;
			end
			if (out_free) begin
				rsp_valid_q <= s1_valid_s1;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.kind        = rsp_kind_q;
	assign rsp.served_id   = rsp_id_q;
	assign rsp.queue_index = rsp_q_q;
endmodule

@@ sv/round_robin_multi_queue_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_multi_queue_scheduler
// session ids queued by low bits, served round-robin on service ticks
// ----------------------------------------------------------------------------
//  channel  dir  fields                           handshake
//  req      in   op, session_id                   valid / ready
//  rsp      out  kind, served_id, queue_index     valid / ready
//
//  one word accepted per cycle while the command queue has room
//  after its word is accepted, a response passes through the command
//  queue and the store read stage, then the response register
//  reset clears pointers, counts and valids at once; no clearing pass
//  a stalled rsp holds the read stage, then pops and drops back up in the
//  command queue and finally hold off req
// ----------------------------------------------------------------------------
module round_robin_multi_queue_scheduler
	import rrmq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rrmq_req_if.sink   req,
	rrmq_rsp_if.source rsp
);
	cmd_t fe_cmd;
	logic fe_cmd_valid;
	logic fe_cmd_ready;
	cmd_t be_cmd;
	logic be_cmd_valid;
	logic be_cmd_ready;

	rrmq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (fe_cmd),
		.cmd_valid(fe_cmd_valid),
		.cmd_ready(fe_cmd_ready)
	);

	rrmq_cmd_fifo u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data (fe_cmd),
		.push_valid(fe_cmd_valid),
		.push_ready(fe_cmd_ready),
		.pop_data  (be_cmd),
		.pop_valid (be_cmd_valid),
		.pop_ready (be_cmd_ready)
	);

	rrmq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (be_cmd),
		.cmd_valid(be_cmd_valid),
		.cmd_ready(be_cmd_ready),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	a_cmd_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		fe_cmd_valid |-> (req.valid && req.ready))
		else $error("command issued without an accepted word");

	a_pop_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(fe_cmd_valid && fe_cmd.op == CMD_READ) |-> (req.op == OP_TICK))
		else $error("pop command from an enqueue word");

	a_enq_target: assert property (@(posedge clk) disable iff (!arst_n)
		(fe_cmd_valid && fe_cmd.op != CMD_READ) |->
		(req.op == OP_ENQ && fe_cmd.q == req.session_id[QIDX_W-1:0] &&
		fe_cmd.id == req.session_id))
		else $error("enqueue command aimed at the wrong queue");
`endif
endmodule
